// ===== hdl/psdw_pkg.sv =====
// ----------------------------------------------------------------------------
// psdw_pkg
// Shared types and constants for the per-source dual-window rate limiter.
// ----------------------------------------------------------------------------
package psdw_pkg;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned IdxW = $clog2(TableEntries);
  localparam int unsigned CntW = $clog2(TableEntries + 1);
  localparam logic [31:0] IdleReset = 32'd300;
  localparam logic [31:0] Max32 = 32'hFFFF_FFFF;

  localparam logic [2:0] RegPeriodA = 3'd0;
  localparam logic [2:0] RegPeriodB = 3'd1;
  localparam logic [2:0] RegLimitA = 3'd2;
  localparam logic [2:0] RegLimitB = 3'd3;
  localparam logic [2:0] RegSpanA = 3'd4;
  localparam logic [2:0] RegSpanB = 3'd5;
  localparam logic [2:0] RegIdle = 3'd6;

  localparam logic OpRecord = 1'b0;
  localparam logic OpCheck = 1'b1;

  localparam logic [1:0] StHit = 2'd0;
  localparam logic [1:0] StNew = 2'd1;
  localparam logic [1:0] StBusy = 2'd2;
  localparam logic [1:0] StMiss = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [31:0] source_addr;
    logic [31:0] now_seconds;
  } in_req_t;

  typedef struct packed {
    logic       filtered;
    logic [1:0] status;
  } out_res_t;

  typedef struct packed {
    logic [31:0] period_a;
    logic [31:0] period_b;
    logic [31:0] limit_a;
    logic [31:0] limit_b;
    logic [31:0] block_span_a;
    logic [31:0] block_span_b;
    logic [31:0] idle_timeout;
  } cfg_regs_t;

  typedef struct packed {
    logic        blocked;
    logic [31:0] window_start;
    logic [31:0] count;
    logic [31:0] block_start;
  } win_t;

  typedef struct packed {
    logic [31:0] tag;
    logic [31:0] last_use;
    win_t        wa;
    win_t        wb;
  } entry_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_EXEC
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic capture;
    logic execute;
  } ctl_cmd_t;

  typedef struct packed {
    logic clear_done;
  } ctl_sts_t;

endpackage

// ===== hdl/psdw_ctrl.sv =====
// ----------------------------------------------------------------------------
// psdw_ctrl
// Sequencer: clearing pass, then read, execute per request.
// ----------------------------------------------------------------------------
module psdw_ctrl import psdw_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_stall,
  input  logic     out_busy,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd,
  output state_t   state
);

  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR: if (sts.clear_done) state_next = S_IDLE;
      S_IDLE:  if (in_valid && !out_busy) state_next = S_READ;
      S_READ:  state_next = S_EXEC;
      S_EXEC:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_stall = 1'b1;
    unique case (state)
      S_CLEAR: cmd.clear_step = 1'b1;
      S_IDLE: begin
        in_stall = out_busy;
        cmd.capture = in_valid && !out_busy;
      end
      S_READ:  ;
      S_EXEC:  cmd.execute = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== hdl/psdw_dp.sv =====
// ----------------------------------------------------------------------------
// psdw_dp
// Table memory, valid-bit memory and read-modify-write datapath.
// ----------------------------------------------------------------------------
module psdw_dp import psdw_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  ctl_cmd_t  cmd,
  output ctl_sts_t  sts,
  input  in_req_t   req,
  input  cfg_regs_t cfg,
  output logic      res_load,
  output out_res_t  res
);

  entry_t     mem [TableEntries];
  logic       vmem [TableEntries];
  logic [CntW-1:0] clr_cnt;
  in_req_t    cur;
  entry_t     rd;
  logic       rd_v;
  logic [IdxW-1:0] idx;

  logic       fresh, hit, fa, fb;
  entry_t     wr;
  logic       we;
  win_t       na, nb;

  assign idx = cur.source_addr[IdxW-1:0];
  assign sts.clear_done = (clr_cnt == CntW'(TableEntries - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_step && !sts.clear_done) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) cur <= req;
  end

  always_ff @(posedge clk) begin
    rd   <= mem[idx];
    rd_v <= vmem[idx];
    if (we) mem[idx] <= wr;
    if (cmd.clear_step) begin
      vmem[clr_cnt[IdxW-1:0]] <= 1'b0;
    end else if (we) begin
      vmem[idx] <= 1'b1;
    end
  end

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == Max32) ? v : v + 32'd1;
  endfunction

  function automatic logic eval_win(input logic [31:0] now, input logic [31:0] per,
                                    input logic [31:0] lim, input logic [31:0] span,
                                    input win_t w, output win_t o);
    o = w;
    if (per == '0) return 1'b0;
    if (w.blocked && (now - w.block_start) <= span) return 1'b1;
    o.blocked = 1'b0;
    if ((now - w.window_start) <= per) begin
      if (w.count > lim) begin
        o.blocked = 1'b1;
        o.block_start = now;
        return 1'b1;
      end
    end else begin
      o.window_start = now;
      o.count = '0;
    end
    return 1'b0;
  endfunction

  always_comb begin
    fresh = rd_v && ((cur.now_seconds - rd.last_use) <= cfg.idle_timeout);
    hit = fresh && (rd.tag == cur.source_addr);
    fa = eval_win(cur.now_seconds, cfg.period_a, cfg.limit_a, cfg.block_span_a, rd.wa, na);
    fb = eval_win(cur.now_seconds, cfg.period_b, cfg.limit_b, cfg.block_span_b, rd.wb, nb);
    wr = rd;
    we = 1'b0;
    res = '0;
    if (cur.opcode == OpRecord) begin
      if (hit) begin
        wr.wa.count = sat_inc(rd.wa.count);
        wr.wb.count = sat_inc(rd.wb.count);
        wr.last_use = cur.now_seconds;
        res.status = StHit;
      end else if (!fresh) begin
        wr.tag = cur.source_addr;
        wr.last_use = cur.now_seconds;
        wr.wa = '{blocked: 1'b0, window_start: cur.now_seconds,
                  count: 32'd1, block_start: '0};
        wr.wb = '{blocked: 1'b0, window_start: cur.now_seconds,
                  count: 32'd1, block_start: '0};
        res.status = StNew;
      end else begin
        res.status = StBusy;
      end
      we = cmd.execute && (hit || !fresh);
    end else begin
      if (hit) begin
        wr.wa = na;
        wr.wb = nb;
        res.filtered = fa || fb;
        res.status = StHit;
      end else begin
        res.status = StMiss;
      end
      we = cmd.execute && hit;
    end
  end

  assign res_load = cmd.execute;

endmodule

// ===== hdl/per_source_dual_window_rate_limiter_top.sv =====
// ----------------------------------------------------------------------------
// per_source_dual_window_rate_limiter_top
// Per-source request counter with two blocking windows, direct-mapped table.
// ----------------------------------------------------------------------------
// Each request is accepted, then the table is read, then it executes and writes back,
// as set by the single-port table read-modify-write; a result waits in an output
// register, and no new request is accepted while it waits untaken. After reset a
// clearing pass over all TableEntries slots (1024) resets the valid bits; requests stall
// meanwhile, configuration writes are taken at any time.
module per_source_dual_window_rate_limiter_top import psdw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_req_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_res_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  cfg_regs_t cfg;
  ctl_cmd_t  cmd;
  ctl_sts_t  sts;
  state_t    state;
  logic      res_load;
  out_res_t  res;
  logic      out_busy;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{idle_timeout: IdleReset, default: '0};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        RegPeriodA: cfg.period_a <= cfg_data;
        RegPeriodB: cfg.period_b <= cfg_data;
        RegLimitA:  cfg.limit_a <= cfg_data;
        RegLimitB:  cfg.limit_b <= cfg_data;
        RegSpanA:   cfg.block_span_a <= cfg_data;
        RegSpanB:   cfg.block_span_b <= cfg_data;
        RegIdle:    cfg.idle_timeout <= cfg_data;
        default:    ;
      endcase
    end
  end

  // Output register frees once taken; an item waits for it only at capture.
  assign out_busy = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) out_data <= res;
  end

  psdw_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .out_busy, .sts, .cmd, .state
  );

  psdw_dp u_dp (
    .clk, .rst, .cmd, .sts, .req(in_data), .cfg, .res_load, .res
  );

  a_exec_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> !out_valid || !out_stall || $past(!out_valid || !out_stall, 2))
    else $error("result overwrites an untaken result");
  a_one_op: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.clear_step, cmd.capture, cmd.execute}))
    else $error("conflicting commands");
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> in_stall)
    else $error("request accepted during clearing pass");
  a_exec_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> ##1 cmd.execute)
    else $error("accepted request not executed");

endmodule

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the per-source dual-window rate limiter: a stimulus
// table and random record/check traffic mostly over a small address set, predicted
// by a behavioral table model, with idle and stall patterns on both channels.
// ----------------------------------------------------------------------------
module tb;
  import psdw_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Slots = TableEntries;
  localparam int unsigned MaxCycles = 400000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_req_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_res_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  per_source_dual_window_rate_limiter_top u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  typedef struct {
    in_req_t  req;
    logic     chk;
    out_res_t res;
  } stim_row_t;

  cfg_regs_t lim_cfg;
  entry_t    lim_tab [Slots];
  logic      lim_vld [Slots];
  out_res_t  verdicts_due [$];
  int        errors = 0;
  int        n_filtered = 0;
  int        n_status [4];
  int        send_idle = 14;
  int        recv_idle = 50;
  bit        hold_recv = 1'b0;
  longint    cycles = 0;

  function automatic logic win_step(input logic [31:0] now, input logic [31:0] period,
                                    input logic [31:0] lim, input logic [31:0] span,
                                    inout win_t w);
    if (period == 0) return 1'b0;
    if (w.blocked && (now - w.block_start) <= span) return 1'b1;
    w.blocked = 1'b0;
    if ((now - w.window_start) <= period) begin
      if (w.count > lim) begin
        w.blocked = 1'b1;
        w.block_start = now;
        return 1'b1;
      end
    end else begin
      w.window_start = now;
      w.count = 0;
    end
    return 1'b0;
  endfunction

  function automatic out_res_t predict_verdict(input in_req_t r);
    int unsigned s;
    logic fresh, hit, fa, fb;
    out_res_t o;
    entry_t e;
    s = r.source_addr % Slots;
    e = lim_tab[s];
    fresh = lim_vld[s] && ((r.now_seconds - e.last_use) <= lim_cfg.idle_timeout);
    hit = fresh && e.tag == r.source_addr;
    o = '0;
    if (r.opcode == OpRecord) begin
      if (hit) begin
        if (e.wa.count != Max32) e.wa.count++;
        if (e.wb.count != Max32) e.wb.count++;
        e.last_use = r.now_seconds;
        o.status = StHit;
      end else if (!fresh) begin
        lim_vld[s] = 1'b1;
        e.tag = r.source_addr;
        e.last_use = r.now_seconds;
        e.wa = '{blocked: 1'b0, window_start: r.now_seconds, count: 1, block_start: 0};
        e.wb = e.wa;
        o.status = StNew;
      end else begin
        o.status = StBusy;
      end
    end else if (hit) begin
      fa = win_step(r.now_seconds, lim_cfg.period_a, lim_cfg.limit_a,
                    lim_cfg.block_span_a, e.wa);
      fb = win_step(r.now_seconds, lim_cfg.period_b, lim_cfg.limit_b,
                    lim_cfg.block_span_b, e.wb);
      o.filtered = fa | fb;
      o.status = StHit;
    end else begin
      o.status = StMiss;
    end
    lim_tab[s] = e;
    return o;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MaxCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) out_stall <= hold_recv || ($urandom_range(99) < recv_idle);
  end

  always @(posedge clk) begin
    out_res_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $display("%0t unexpected verdict %p", $time, out_data);
        errors++;
      end else begin
        exp_res = verdicts_due.pop_front();
        if (out_data.filtered !== exp_res.filtered) begin
          $display("%0t filtered exp %0d got %0d", $time, exp_res.filtered,
                   out_data.filtered);
          errors++;
        end
        if (out_data.status !== exp_res.status) begin
          $display("%0t status exp %0d got %0d", $time, exp_res.status, out_data.status);
          errors++;
        end
        n_status[out_data.status]++;
        if (out_data.filtered === 1'b1) n_filtered++;
      end
    end
  end

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      RegPeriodA: lim_cfg.period_a = val;
      RegPeriodB: lim_cfg.period_b = val;
      RegLimitA: lim_cfg.limit_a = val;
      RegLimitB: lim_cfg.limit_b = val;
      RegSpanA: lim_cfg.block_span_a = val;
      RegSpanB: lim_cfg.block_span_b = val;
      RegIdle: lim_cfg.idle_timeout = val;
      default: ;
    endcase
  endtask

  // Lower valid only across idle gaps; the caller drops it after the last request.
  task automatic send_request(input in_req_t r, input logic chk, input out_res_t typed);
    out_res_t p;
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    p = predict_verdict(r);
    if (chk && p !== typed) begin
      $display("%0t table row exp %p predictor %p", $time, typed, p);
      errors++;
    end
    verdicts_due.push_back(p);
    in_valid <= 1'b1;
    in_data <= r;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain;
    while (verdicts_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_all(input logic [31:0] pa, input logic [31:0] pb,
                         input logic [31:0] la, input logic [31:0] lb,
                         input logic [31:0] sa, input logic [31:0] sb,
                         input logic [31:0] idle);
    drain();
    write_reg(RegPeriodA, pa);
    write_reg(RegPeriodB, pb);
    write_reg(RegLimitA, la);
    write_reg(RegLimitB, lb);
    write_reg(RegSpanA, sa);
    write_reg(RegSpanB, sb);
    write_reg(RegIdle, idle);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(input int n, input int n_addr, input logic [31:0] base);
    in_req_t r;
    logic [31:0] now;
    now = $urandom;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0) begin
        r = {1'($urandom), 32'($urandom), 32'($urandom)};
      end else begin
        now = now + $urandom_range(3) + (($urandom_range(19) == 0) ? $urandom_range(400) : 0);
        r.opcode = ($urandom_range(2) == 0) ? OpCheck : OpRecord;
        r.source_addr = base + ($urandom_range(n_addr - 1) * (($urandom_range(3) == 0) ?
                        Slots : 1));
        r.now_seconds = now;
      end
      send_request(r, 1'b0, '0);
    end
    in_valid <= 1'b0;
  endtask

  stim_row_t table_rows [$];

  initial begin
    lim_cfg = '0;
    lim_cfg.idle_timeout = IdleReset;
    foreach (lim_vld[i]) begin
      lim_vld[i] = 1'b0;
      lim_tab[i] = '0;
    end
    foreach (n_status[i]) n_status[i] = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    table_rows = '{
      '{'{OpCheck, 32'h0, 32'h0}, 1'b1, '{1'b0, StMiss}},
      '{'{OpRecord, 32'h0, 32'h0}, 1'b1, '{1'b0, StNew}},
      '{'{OpRecord, 32'h0, 32'd5}, 1'b1, '{1'b0, StHit}},
      '{'{OpRecord, 32'h400, 32'd6}, 1'b1, '{1'b0, StBusy}},
      '{'{OpCheck, 32'h400, 32'd6}, 1'b1, '{1'b0, StMiss}},
      '{'{OpCheck, 32'h0, 32'd6}, 1'b1, '{1'b0, StHit}},
      '{'{OpRecord, 32'h400, 32'd306}, 1'b1, '{1'b0, StNew}},
      '{'{OpRecord, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1, '{1'b0, StNew}},
      '{'{OpRecord, 32'hFFFF_FFFF, 32'h0000_0010}, 1'b1, '{1'b0, StHit}},
      '{'{OpCheck, 32'hFFFF_FFFF, 32'h0000_0020}, 1'b1, '{1'b0, StHit}},
      '{'{OpCheck, 32'hFFFF_FFFF, 32'h0000_0200}, 1'b1, '{1'b0, StMiss}},
      '{'{OpRecord, 32'hAAAA_5555, 32'h5555_AAAA}, 1'b1, '{1'b0, StNew}}
    };
    foreach (table_rows[i]) send_request(table_rows[i].req, table_rows[i].chk,
                                         table_rows[i].res);
    in_valid <= 1'b0;

    set_all(32'd10, 32'd40, 32'd2, 32'd5, 32'd4, 32'd20, 32'd100);
    table_rows = '{
      '{'{OpRecord, 32'h1234, 32'd1000}, 1'b0, '{1'b0, StHit}},
      '{'{OpRecord, 32'h1234, 32'd1001}, 1'b0, '{1'b0, StHit}},
      '{'{OpRecord, 32'h1234, 32'd1002}, 1'b0, '{1'b0, StHit}},
      '{'{OpCheck, 32'h1234, 32'd1003}, 1'b0, '{1'b0, StHit}},
      '{'{OpCheck, 32'h1234, 32'd1006}, 1'b0, '{1'b0, StHit}},
      '{'{OpCheck, 32'h1234, 32'd1008}, 1'b0, '{1'b0, StHit}},
      '{'{OpCheck, 32'h1234, 32'd1030}, 1'b0, '{1'b0, StHit}},
      '{'{OpCheck, 32'h1234, 32'd1050}, 1'b0, '{1'b0, StHit}}
    };
    foreach (table_rows[i]) send_request(table_rows[i].req, 1'b0, '0);
    in_valid <= 1'b0;

    set_all(32'd8, 32'd30, 32'd3, 32'd6, 32'd5, 32'd12, 32'd60);
    random_phase(350, 24, $urandom);
    send_idle = 50;
    recv_idle = 14;
    set_all(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
            32'hFFFF_FFFF);
    random_phase(300, 40, $urandom);
    send_idle = 0;
    recv_idle = 0;
    set_all(32'd0, 32'd3, 32'hFFFF_FFFF, 32'd1, 32'd0, 32'd2, 32'd0);
    random_phase(250, 16, $urandom);
    set_all(32'd5, 32'd9, 32'd1, 32'd2, 32'd3, 32'd4, 32'd30);
    fork
      begin
        hold_recv = 1'b1;
        repeat (300) @(posedge clk);
        hold_recv = 1'b0;
      end
      random_phase(320, 20, $urandom);
    join
    drain();
    repeat (10) @(posedge clk);

    $display("Covered %0d hits, %0d installs, %0d busy, %0d check misses, %0d filtered",
             n_status[0], n_status[1], n_status[2], n_status[3], n_filtered);
    $display("Reset defaults and five register settings, including all-ones and zero extremes");
    if (errors == 0 && verdicts_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/psdw_pkg.sv
hdl/psdw_ctrl.sv
hdl/psdw_dp.sv
hdl/per_source_dual_window_rate_limiter_top.sv
dv/tb.sv
